>>> sv/ffsa_pkg.sv
// shared types and constants of the first-free slot allocator
package ffsa_pkg;

	localparam int S_DATA_W = 24;
	localparam int S_USER_W = 2;
	localparam int M_DATA_W = 48;
	localparam int CFG_W    = 9;

	localparam logic [CFG_W-1:0] SLOT_COUNT_RST = 9'd256;

	typedef enum logic [1:0] {
		ACT_RESERVE = 2'd0,
		ACT_RELEASE = 2'd1,
		ACT_QUERY   = 2'd2
	} action_t;

	// one item as it travels down the row of slot cells
	typedef struct packed {
		logic        valid;
		action_t     action;
		logic [15:0] id;
		logic [7:0]  idx;
		logic        ok;
		logic [7:0]  granted;
		logic [15:0] owner;
	} wave_t;

endpackage

>>> sv/ffsa_cell.sv
// one slot cell: holds one owner id and acts on the item passing through
module ffsa_cell #(
	parameter int SLOT = 0,
	parameter int ID_W = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           in_range,
	input  ffsa_pkg::wave_t wave_in,
	output ffsa_pkg::wave_t wave_out
);
	import ffsa_pkg::*;

	logic [ID_W-1:0] owner_q;
	logic [ID_W-1:0] owner_d;
	wave_t           wave_s1;
	wave_t           wave_d;
	logic            hit;
	logic            empty;
	logic            take_res;

	assign hit   = (32'(wave_in.idx) == 32'(SLOT));
	assign empty = (owner_q == '0);

	always_comb begin
		wave_d   = wave_in;
		owner_d  = owner_q;
		take_res = 1'b0;
		if (wave_in.valid && in_range) begin
			case (wave_in.action)
				ACT_RESERVE: begin
					// first empty slot grabs the id, later cells see ok already set
					if (!wave_in.ok && wave_in.id != '0 && empty) begin
						take_res       = 1'b1;
						owner_d        = wave_in.id[ID_W-1:0];
						wave_d.ok      = 1'b1;
						wave_d.granted = 8'(SLOT);
					end
				end
				ACT_RELEASE: begin
					if (hit && !empty) begin
						owner_d      = '0;
						wave_d.ok    = 1'b1;
						wave_d.owner = 16'(owner_q);
					end
				end
				ACT_QUERY: begin
					if (hit) begin
						wave_d.ok    = 1'b1;
						wave_d.owner = 16'(owner_q);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owner_q <= '0;
			wave_s1 <= '0;
		end else if (adv) begin
			owner_q <= owner_d;
			wave_s1 <= wave_d;
		end
	end

	assign wave_out = wave_s1;

	a_claim_fills: assert property (@(posedge clk) disable iff (!arst_n)
		adv && take_res |=> owner_q != '0)
		else $error("slot claimed by a reserve reads as empty");

	a_ok_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		adv && wave_in.valid && wave_in.ok |=> wave_s1.valid && wave_s1.ok)
		else $error("item lost its success mark in a cell");

endmodule

>>> sv/ffsa_tally.sv
// end of the cell row: occupancy counter and output register
module ffsa_tally #(
	parameter int MAX_SLOTS = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ffsa_pkg::wave_t                 wave_in,
	input  logic [((($clog2(MAX_SLOTS+1)) > 9) ? $clog2(MAX_SLOTS+1) : 9)-1:0] active_cnt,
	output logic                            adv,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [ffsa_pkg::M_DATA_W-1:0]   m_tdata,
	output logic                            m_tuser
);
	import ffsa_pkg::*;

	localparam int CNT_W = $clog2(MAX_SLOTS + 1);
	localparam int CW    = (CNT_W > 9) ? CNT_W : 9;

	logic             out_valid_q;
	logic             ok_q;
	logic [7:0]       granted_q;
	logic [15:0]      owner_q;
	logic [8:0]       free_q;
	logic [8:0]       used_q;
	logic [CNT_W-1:0] occ_q;
	logic [CNT_W-1:0] occ_d;
	logic [CW-1:0]    occ_w;
	logic [CW-1:0]    free_w;

	assign adv = !out_valid_q || m_tready;

	always_comb begin
		occ_d = occ_q;
		if (wave_in.valid && wave_in.ok) begin
			case (wave_in.action)
				ACT_RESERVE: occ_d = occ_q + 1'b1;
				ACT_RELEASE: begin
					if (occ_q != '0) begin
						occ_d = occ_q - 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
		occ_w  = CW'(occ_d);
		free_w = (active_cnt > occ_w) ? (active_cnt - occ_w) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			occ_q       <= '0;
		end else if (adv) begin
			out_valid_q <= wave_in.valid;
			if (wave_in.valid) begin
				occ_q <= occ_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && wave_in.valid) begin
			ok_q      <= wave_in.ok;
			granted_q <= wave_in.granted;
			owner_q   <= wave_in.owner;
			free_q    <= free_w[8:0];
			used_q    <= occ_w[8:0];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = ok_q;
	assign m_tdata  = {6'b0, used_q, free_q, owner_q, granted_q};

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CNT_W'(MAX_SLOTS))
		else $error("occupied count above table depth");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !ok_q |-> granted_q == '0 && owner_q == '0)
		else $error("failed item carries a slot or an owner");

	a_reserve_count: assert property (@(posedge clk) disable iff (!arst_n)
		adv && wave_in.valid && wave_in.ok && wave_in.action == ACT_RESERVE
		|=> occ_q == $past(occ_q) + 1'b1)
		else $error("successful reserve did not bump the occupied count");

endmodule

>>> sv/first_free_slot_allocator.sv
// top level of the first-free slot allocator: config register, cell row, output stage
//
// usage
//   s_* channel takes one request item: s_tuser = action (0 reserve, 1 release,
//   2 query), s_tdata = owner_id and slot_index. m_* channel returns one result
//   item per request in request order: m_tuser = ok, m_tdata = granted_slot,
//   slot_owner, free_slots, used_slots. cfg_* writes slot_count, only while idle.
//   the table is a row of MAX_SLOTS cells, one slot each. an item walks the row
//   one cell per cycle; every cell reserves, releases or reads its own slot as
//   the item passes, so the first empty cell in index order wins a reserve.
//   an accepted item passes every cell register and the output register
//   before m_tvalid; the row is a systolic pipeline, so a new item can enter
//   every cycle and throughput is one item per cycle while m_tready stays high.
//   reset empties every slot, zeroes the occupied count and sets slot_count to
//   256. when the receiver stalls the whole row freezes and s_tready drops;
//   the result waiting in the output register holds until it is taken.
module first_free_slot_allocator #(
	parameter int MAX_SLOTS = 256,
	parameter int ID_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [ffsa_pkg::S_DATA_W-1:0] s_tdata,  // owner_id[15:0], slot_index[23:16]
	input  logic [ffsa_pkg::S_USER_W-1:0] s_tuser,  // action[1:0]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [ffsa_pkg::M_DATA_W-1:0] m_tdata,  // granted_slot[7:0], slot_owner[23:8],
	                                                // free_slots[32:24], used_slots[41:33]
	output logic                          m_tuser,  // ok[0]
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ffsa_pkg::CFG_W-1:0]    cfg_data  // slot_count[8:0]
);
	import ffsa_pkg::*;

	localparam int CNT_W = $clog2(MAX_SLOTS + 1);
	localparam int CW    = (CNT_W > 9) ? CNT_W : 9;
	// ids arrive on a 16-bit field, so stored ids never need more bits than that
	localparam int ID_W  = (ID_BITS < 16) ? ID_BITS : 16;

	logic [CFG_W-1:0]     slot_count_q;
	logic [CW-1:0]        slot_count_w;
	logic [CW-1:0]        active_cnt;
	logic [MAX_SLOTS-1:0] in_rng;
	logic                 adv;
	wave_t                wave [MAX_SLOTS+1];

	// config register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= SLOT_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			slot_count_q <= cfg_data;
		end
	end

	// active count saturates at the table depth
	assign slot_count_w = CW'(slot_count_q);
	assign active_cnt   = (slot_count_w > CW'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : slot_count_w;

	// request enters the row at cell 0 with the id masked to its stored width
	assign s_tready = adv;

	always_comb begin
		wave[0]         = '0;
		wave[0].valid   = s_tvalid;
		wave[0].action  = action_t'(s_tuser);
		wave[0].id      = 16'(s_tdata[ID_W-1:0]);
		wave[0].idx     = s_tdata[23:16];
	end

	// row of slot cells, each one also knows whether it lies below the active count
	for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
		assign in_rng[g] = (CW'(g) < active_cnt);

		ffsa_cell #(
			.SLOT (g),
			.ID_W (ID_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.in_range (in_rng[g]),
			.wave_in  (wave[g]),
			.wave_out (wave[g+1])
		);
	end

	// occupancy bookkeeping and output register; its advance signal drives the row
	ffsa_tally #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_tally (
		.clk        (clk),
		.arst_n     (arst_n),
		.wave_in    (wave[MAX_SLOTS]),
		.active_cnt (active_cnt),
		.adv        (adv),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule

>>> tb/ffsa_checker.sv
// result checker for the first-free slot allocator: slot table model and result comparison
`timescale 1ns / 100ps

module ffsa_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [ffsa_pkg::S_DATA_W-1:0] s_tdata,
	input  logic [ffsa_pkg::S_USER_W-1:0] s_tuser,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [ffsa_pkg::M_DATA_W-1:0] m_tdata,
	input  logic                          m_tuser,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [ffsa_pkg::CFG_W-1:0]    cfg_data,
	output int                            fail_count,
	output int                            pending
);
	import ffsa_pkg::*;

	localparam int TABLE_DEPTH = 256;

	typedef struct packed {
		logic        ok;
		logic [7:0]  granted;
		logic [15:0] owner;
		logic [8:0]  free;
		logic [8:0]  used;
	} slot_result_t;

	logic [15:0]  owner_tbl [TABLE_DEPTH];
	logic [8:0]   held;
	logic [CFG_W-1:0] limit_reg;
	slot_result_t results_due [$];
	slot_result_t want, seen;
	int           mismatch_total = 0;

	// applies one request to the table model and returns the result it should give
	function automatic slot_result_t apply_request(logic [1:0] act, logic [15:0] id,
			logic [7:0] idx);
		slot_result_t r;
		int span;
		span = (limit_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(limit_reg);
		r = '0;
		case (act)
			ACT_RESERVE: begin
				if (id != 16'd0) begin
					for (int i = 0; i < span && !r.ok; i++) begin
						if (owner_tbl[i] == 16'd0) begin
							owner_tbl[i] = id;
							held = held + 9'd1;
							r.granted = i[7:0];
							r.ok = 1'b1;
						end
					end
				end
			end
			ACT_RELEASE: begin
				if (int'(idx) < span && owner_tbl[idx] != 16'd0) begin
					r.owner = owner_tbl[idx];
					owner_tbl[idx] = 16'd0;
					if (held > 0)
						held = held - 9'd1;
					r.ok = 1'b1;
				end
			end
			ACT_QUERY: begin
				if (int'(idx) < span) begin
					r.owner = owner_tbl[idx];
					r.ok = 1'b1;
				end
			end
			default: ;
		endcase
		r.used = held;
		r.free = (span > int'(held)) ? 9'(span - int'(held)) : 9'd0;
		return r;
	endfunction

	task automatic check_field(string name, int unsigned exp_val, int unsigned got_val);
		if (exp_val != got_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, got_val);
			mismatch_total++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TABLE_DEPTH; k++)
				owner_tbl[k] = 16'd0;
			held = 9'd0;
			limit_reg = SLOT_COUNT_RST;
			results_due.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				limit_reg = cfg_data;
			if (s_tvalid && s_tready)
				results_due.push_back(apply_request(s_tuser, s_tdata[15:0], s_tdata[23:16]));
			if (m_tvalid && m_tready) begin
				seen = {m_tuser, m_tdata[7:0], m_tdata[23:8], m_tdata[32:24], m_tdata[41:33]};
				if (results_due.size() == 0) begin
					$error("result item with no request waiting");
					mismatch_total++;
				end else begin
					want = results_due.pop_front();
					check_field("ok", want.ok, seen.ok);
					check_field("granted_slot", want.granted, seen.granted);
					check_field("slot_owner", want.owner, seen.owner);
					check_field("free_slots", want.free, seen.free);
					check_field("used_slots", want.used, seen.used);
				end
			end
			pending <= results_due.size();
		end
		fail_count <= mismatch_total;
	end

endmodule

>>> tb/first_free_slot_allocator_tb.sv
// testbench top for the first-free slot allocator: stimulus, idling, pressure and verdict
`timescale 1ns / 100ps

module first_free_slot_allocator_tb;
	import ffsa_pkg::*;

	// the request channel also carries the unused action code
	localparam logic [1:0] ACT_UNDEFINED = 2'd3;
	localparam int         HOLD_CYCLES   = 700;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata   = '0;  // owner_id[15:0], slot_index[23:16]
	logic [S_USER_W-1:0] s_tuser   = '0;  // action[1:0]
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;  // granted_slot[7:0], slot_owner[23:8],
	                               // free_slots[32:24], used_slots[41:33]
	logic                m_tuser;  // ok[0]
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CFG_W-1:0]    cfg_data  = '0;  // slot_count[8:0]

	int   fail_count;
	int   pending;

	// idling knobs, in percent of cycles
	int   send_idle_pct  = 0;
	int   take_stall_pct = 0;
	logic hold_on        = 1'b0;
	logic pressure_go    = 1'b0;

	// slot count as the block sees it, used only to aim indexes
	int   active_slots   = 256;

	first_free_slot_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	ffsa_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	// receiver: random stalls, or a solid hold-off while the pressure window is open
	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else if (hold_on)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99, 0) >= take_stall_pct);
	end

	// pressure window: receiver holds off long enough for the cell row to fill
	// and push back on the request side
	initial begin
		wait (pressure_go);
		@(posedge clk);
		hold_on <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_on <= 1'b0;
	end

	// generous limit on the whole run
	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// offers one request item, with random gaps before it, and waits for the handshake
	task automatic put_request(logic [1:0] act, logic [15:0] id, logic [7:0] idx);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {idx, id};
		do @(posedge clk); while (!s_tready);
	endtask

	// stops offering and waits until every result has come back
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// slot_count write, only with the block idle
	task automatic write_slot_count(logic [CFG_W-1:0] value);
		settle();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		active_slots = (value > 256) ? 256 : int'(value);
		@(posedge clk);
	endtask

	// one random request; the rest of the percentages go to the unused code
	task automatic random_request(int reserve_pct, int release_pct, int query_pct);
		int        pick;
		logic [1:0] act;
		logic [15:0] id;
		logic [7:0]  idx;
		pick = $urandom_range(99, 0);
		if (pick < reserve_pct)
			act = ACT_RESERVE;
		else if (pick < reserve_pct + release_pct)
			act = ACT_RELEASE;
		else if (pick < reserve_pct + release_pct + query_pct)
			act = ACT_QUERY;
		else
			act = ACT_UNDEFINED;
		// mostly nonzero ids, now and then zero or all ones
		case ($urandom_range(19, 0))
			0:       id = 16'd0;
			1:       id = 16'hFFFF;
			default: id = 16'($urandom_range(65535, 1));
		endcase
		// mostly aimed inside the active range, sometimes anywhere
		if (active_slots > 0 && $urandom_range(9, 0) < 8)
			idx = 8'($urandom_range(active_slots - 1, 0));
		else
			idx = 8'($urandom_range(255, 0));
		put_request(act, id, idx);
	endtask

	task automatic random_run(int n, int reserve_pct, int release_pct, int query_pct);
		repeat (n) random_request(reserve_pct, release_pct, query_pct);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: full table size after reset
		put_request(ACT_RESERVE, 16'h0000, 8'd0);    // zero id rejected
		put_request(ACT_RESERVE, 16'hFFFF, 8'd0);    // lands in slot 0
		put_request(ACT_RESERVE, 16'h0001, 8'd0);    // slot 1
		put_request(ACT_RESERVE, 16'h8000, 8'd0);    // slot 2
		put_request(ACT_QUERY, 16'h0000, 8'd0);
		put_request(ACT_QUERY, 16'h0000, 8'd255);    // empty slot reads as zero
		put_request(ACT_RELEASE, 16'h0000, 8'd1);
		put_request(ACT_RELEASE, 16'h0000, 8'd1);    // already empty
		put_request(ACT_RESERVE, 16'h1234, 8'd0);    // refills the hole at slot 1
		put_request(ACT_UNDEFINED, 16'hFFFF, 8'd0);
		put_request(ACT_RELEASE, 16'hFFFF, 8'd255);  // empty top slot

		// shrink below the occupied slots: used stays, free saturates
		write_slot_count(9'd2);
		put_request(ACT_RESERVE, 16'h0007, 8'd0);    // no empty slot in range
		put_request(ACT_RELEASE, 16'h0000, 8'd2);    // index out of range
		put_request(ACT_QUERY, 16'h0000, 8'd2);
		put_request(ACT_RELEASE, 16'h0000, 8'd0);
		put_request(ACT_RESERVE, 16'h0005, 8'd0);

		// no slots at all
		write_slot_count(9'd0);
		put_request(ACT_RESERVE, 16'h0009, 8'd0);
		put_request(ACT_QUERY, 16'h0000, 8'd0);
		put_request(ACT_RELEASE, 16'h0000, 8'd0);

		// register above the table depth saturates
		write_slot_count(9'd511);
		put_request(ACT_QUERY, 16'h0000, 8'd2);
		put_request(ACT_RELEASE, 16'h0000, 8'd2);
		put_request(ACT_QUERY, 16'h0000, 8'd255);

		// back to back, reserve heavy so the table fills; receiver held off a while
		write_slot_count(9'd256);
		pressure_go <= 1'b1;
		random_run(270, 94, 3, 2);

		// sparse sender, release heavy on a full table
		write_slot_count(9'd300);
		send_idle_pct = 88;
		random_run(60, 30, 40, 25);

		// small window over a crowded table, slow receiver
		send_idle_pct = 0;
		take_stall_pct <= 88;
		write_slot_count(9'd7);
		random_run(70, 45, 35, 15);

		// single slot, light idling on both sides
		send_idle_pct = 15;
		take_stall_pct <= 15;
		write_slot_count(9'd1);
		random_run(40, 45, 35, 15);

		write_slot_count(9'($urandom_range(255, 2)));
		random_run(50, 45, 35, 15);

		// full size again, no idling
		send_idle_pct = 0;
		take_stall_pct <= 0;
		write_slot_count(9'd256);
		random_run(40, 40, 35, 20);

		// drain, then let the cell row run empty
		settle();
		repeat (300) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> first_free_slot_allocator.f
sv/ffsa_pkg.sv
sv/ffsa_cell.sv
sv/ffsa_tally.sv
sv/first_free_slot_allocator.sv
tb/ffsa_checker.sv
tb/first_free_slot_allocator_tb.sv
